@@ rtl/core/wtsu_pkg.sv @@
`timescale 1ns / 1ps

package wtsu_pkg;

  // v = spread^2 / count, four quotient bits per stage
  localparam int unsigned VDIV_BITS   = 4;
  localparam int unsigned VDIV_STAGES = 64 / VDIV_BITS;

  // t branch: d^2 * 2^32 / V (62 quotient bits), then a 62-bit square root
  localparam int unsigned TDIV_STEPS = 62;
  localparam int unsigned SQRT_STEPS = TDIV_STEPS / 2;

  // freedom branch: three groups of limb multiplies, then a 32-bit quotient
  localparam int unsigned MUL_GROUPS = 3;
  localparam int unsigned MUL_DEPTH  = 3;
  localparam int unsigned MUL_LANES  = 3;
  localparam int unsigned MUL_XL     = 4;
  localparam int unsigned MUL_YL     = 3;
  localparam int unsigned FDIV_STEPS = 32;

  localparam int unsigned T_LAT = 1 + TDIV_STEPS + SQRT_STEPS;
  localparam int unsigned F_LAT = MUL_GROUPS * MUL_DEPTH + 1 + FDIV_STEPS;
  localparam int unsigned F_PAD = T_LAT - F_LAT;
  localparam int unsigned NSTG  = 3 + VDIV_STAGES + T_LAT;

  localparam logic [31:0] T_POS_LIM = 32'h7FFF_FFFF;
  localparam logic [31:0] T_NEG_LIM = 32'h8000_0000;
  localparam logic [31:0] F_SAT     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [32:0] diff;
    logic [31:0]        sa;
    logic [31:0]        sb;
    logic [15:0]        na;
    logic [15:0]        nb;
  } in_t;

  typedef struct packed {
    logic [63:0] sq_a;
    logic [63:0] sq_b;
    logic [64:0] dsq;
    logic        neg;
    logic [15:0] na;
    logic [15:0] nb;
  } prep_t;

  typedef struct packed {
    logic [63:0] sh;
    logic [15:0] rem;
    logic [15:0] dv;
  } vlane_t;

  typedef struct packed {
    vlane_t      la;
    vlane_t      lb;
    logic [64:0] dsq;
    logic        neg;
    logic        zcnt;
    logic        few;
  } vd_t;

  typedef struct packed {
    logic neg;
    logic zvar;
    logic few;
  } flg_t;

  typedef struct packed {
    logic [63:0] v1;
    logic [63:0] v2;
    logic [64:0] vs;
    logic [15:0] a;
    logic [15:0] b;
    logic [64:0] dsq;
    flg_t        flg;
  } vsum_t;

  typedef struct packed {
    logic [32*MUL_XL-1:0] x;
    logic [32*MUL_YL-1:0] y;
  } mop_t;

  typedef logic [MUL_XL-1:0][MUL_YL-1:0][63:0] pp_t;
  typedef logic [MUL_YL-1:0][32*MUL_XL+31:0]   rows_t;
  typedef logic [32*(MUL_XL+MUL_YL)-1:0]        prod_t;

  typedef struct packed {
    logic [63:0]  v1;
    logic [63:0]  v2;
    logic [64:0]  vs;
    logic [15:0]  a;
    logic [15:0]  b;
    logic [144:0] den;
  } fside_t;

  typedef struct packed {
    logic [64:0] rem;
    logic [61:0] sh;
    logic [64:0] vs;
    logic        ovf;
    flg_t        flg;
  } tdiv_t;

  typedef struct packed {
    logic [61:0] x;
    logic [30:0] root;
    logic [32:0] rem;
    logic        ovf;
    flg_t        flg;
  } sqrt_t;

  typedef struct packed {
    logic [144:0] rem;
    logic [31:0]  sh;
    logic [144:0] den;
    logic         ovf;
  } fdiv_t;

  typedef struct packed {
    logic [31:0] q;
    logic        ovf;
  } fres_t;

  function automatic vlane_t vdiv_step(input vlane_t l);
    vlane_t      r;
    logic [16:0] t;
    logic        ge;
    r = l;
    for (int i = 0; i < VDIV_BITS; i++) begin
      t     = {r.rem, r.sh[63]};
      ge    = (t >= {1'b0, r.dv});
      r.rem = ge ? 16'(t - {1'b0, r.dv}) : t[15:0];
      r.sh  = {r.sh[62:0], ge};
    end
    return r;
  endfunction

  function automatic tdiv_t tdiv_step(input tdiv_t s);
    tdiv_t       r;
    logic [65:0] t;
    logic        ge;
    r     = s;
    t     = {s.rem, s.sh[61]};
    ge    = (t >= {1'b0, s.vs});
    r.rem = ge ? 65'(t - {1'b0, s.vs}) : t[64:0];
    r.sh  = {s.sh[60:0], ge};
    return r;
  endfunction

  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t       r;
    logic [34:0] t;
    logic [32:0] trial;
    logic        ge;
    r      = s;
    t      = {s.rem, s.x[61:60]};
    trial  = {s.root, 2'b01};
    ge     = (t >= {2'b00, trial});
    r.rem  = ge ? 33'(t - {2'b00, trial}) : t[32:0];
    r.root = {s.root[29:0], ge};
    r.x    = {s.x[59:0], 2'b00};
    return r;
  endfunction

  function automatic fdiv_t fdiv_step(input fdiv_t s);
    fdiv_t        r;
    logic [145:0] t;
    logic         ge;
    r     = s;
    t     = {s.rem, s.sh[31]};
    ge    = (t >= {1'b0, s.den});
    r.rem = ge ? 145'(t - {1'b0, s.den}) : t[144:0];
    r.sh  = {s.sh[30:0], ge};
    return r;
  endfunction

  // 32x32 partial products of one limb multiply
  function automatic pp_t mul_pp(input mop_t m);
    pp_t p;
    for (int i = 0; i < MUL_XL; i++) begin
      for (int j = 0; j < MUL_YL; j++) begin
        p[i][j] = m.x[i*32 +: 32] * m.y[j*32 +: 32];
      end
    end
    return p;
  endfunction

  function automatic rows_t mul_rows(input pp_t p);
    rows_t r;
    for (int j = 0; j < MUL_YL; j++) begin
      r[j] = '0;
      for (int i = 0; i < MUL_XL; i++) begin
        r[j] = r[j] + ((32*MUL_XL+32)'(p[i][j]) << (32 * i));
      end
    end
    return r;
  endfunction

  function automatic prod_t mul_sum(input rows_t r);
    prod_t s;
    s = '0;
    for (int j = 0; j < MUL_YL; j++) begin
      s = s + ($bits(prod_t)'(r[j]) << (32 * j));
    end
    return s;
  endfunction

endpackage

@@ rtl/core/welch_t_statistic_unit.sv @@
`timescale 1ns / 1ps

// Welch t statistic and Welch-Satterthwaite degrees of freedom from two sample
// summaries (Q16.16 mean and standard deviation, 16-bit count). Fully pipelined:
// one request per clock while stall_o is low; the longest path is the 62-step t
// quotient and 31-step square root chain, one bit per stage. A held result (valid_o
// high, stall_i high) freezes every stage, so stall_o follows stall_i while a result
// waits. zero_variance_o forces both results to 0; small_count_o forces freedom_o
// to 0; clipped_o marks a saturated t_value_o or freedom_o. All results truncate
// toward zero.
module welch_t_statistic_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] mean_a_i,
  input  logic        [31:0] spread_a_i,
  input  logic signed [31:0] mean_b_i,
  input  logic        [31:0] spread_b_i,
  input  logic        [15:0] count_a_i,
  input  logic        [15:0] count_b_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [31:0] t_value_o,
  output logic        [31:0] freedom_o,
  output logic               clipped_o,
  output logic               zero_variance_o,
  output logic               small_count_o
);
  import wtsu_pkg::*;

  logic adv;
  logic vld_q [NSTG];
  logic out_vld_q;

  // whole pipe moves unless the output holds an untaken result
  assign stall_o = out_vld_q & stall_i;
  assign adv     = ~stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) vld_q[k] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k < NSTG; k++) vld_q[k] <= vld_q[k-1];
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  // ---- input register: mean difference
  in_t in_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q.diff <= {mean_a_i[31], mean_a_i} - {mean_b_i[31], mean_b_i};
      in_q.sa   <= spread_a_i;
      in_q.sb   <= spread_b_i;
      in_q.na   <= count_a_i;
      in_q.nb   <= count_b_i;
    end
  end

  // ---- squares
  logic signed [65:0] dsq_full;
  prep_t              prep_q;
  assign dsq_full = $signed(in_q.diff) * $signed(in_q.diff);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prep_q.sq_a <= in_q.sa * in_q.sa;
      prep_q.sq_b <= in_q.sb * in_q.sb;
      prep_q.dsq  <= dsq_full[64:0];
      prep_q.neg  <= in_q.diff[32];
      prep_q.na   <= in_q.na;
      prep_q.nb   <= in_q.nb;
    end
  end

  // ---- per-sample variance, radix-16 long division by the count
  vd_t vd_init;
  vd_t vd_src [VDIV_STAGES];
  vd_t vd_q   [VDIV_STAGES];

  always_comb begin
    vd_init.la.sh  = prep_q.sq_a;
    vd_init.la.rem = '0;
    vd_init.la.dv  = (prep_q.na == '0) ? 16'd1 : prep_q.na;
    vd_init.lb.sh  = prep_q.sq_b;
    vd_init.lb.rem = '0;
    vd_init.lb.dv  = (prep_q.nb == '0) ? 16'd1 : prep_q.nb;
    vd_init.dsq    = prep_q.dsq;
    vd_init.neg    = prep_q.neg;
    vd_init.zcnt   = (prep_q.na == '0) || (prep_q.nb == '0);
    vd_init.few    = (prep_q.na < 16'd2) || (prep_q.nb < 16'd2);
  end

  assign vd_src[0] = vd_init;

  for (genvar k = 0; k < VDIV_STAGES; k++) begin : g_vdiv
    if (k > 0) begin : g_link
      assign vd_src[k] = vd_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        vd_q[k].la   <= vdiv_step(vd_src[k].la);
        vd_q[k].lb   <= vdiv_step(vd_src[k].lb);
        vd_q[k].dsq  <= vd_src[k].dsq;
        vd_q[k].neg  <= vd_src[k].neg;
        vd_q[k].zcnt <= vd_src[k].zcnt;
        vd_q[k].few  <= vd_src[k].few;
      end
    end
  end

  // ---- V = v1 + v2, zero-variance or zero-count detect
  vd_t   vd_last;
  vsum_t vsum_q;
  assign vd_last = vd_q[VDIV_STAGES-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vsum_q.v1       <= vd_last.la.sh;
      vsum_q.v2       <= vd_last.lb.sh;
      vsum_q.vs       <= {1'b0, vd_last.la.sh} + {1'b0, vd_last.lb.sh};
      vsum_q.a        <= 16'(vd_last.la.dv - 16'd1);
      vsum_q.b        <= 16'(vd_last.lb.dv - 16'd1);
      vsum_q.dsq      <= vd_last.dsq;
      vsum_q.flg.neg  <= vd_last.neg;
      vsum_q.flg.zvar <= vd_last.zcnt ||
                         ((vd_last.la.sh == '0) && (vd_last.lb.sh == '0));
      vsum_q.flg.few  <= vd_last.few;
    end
  end

  // ---- t branch: floor(d^2 * 2^32 / V), one quotient bit per stage
  tdiv_t td_q [TDIV_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      td_q[0].rem <= 65'(vsum_q.dsq[64:30]);
      td_q[0].sh  <= {vsum_q.dsq[29:0], 32'h0};
      td_q[0].vs  <= vsum_q.vs;
      td_q[0].ovf <= {30'h0, vsum_q.dsq[64:30]} >= vsum_q.vs;
      td_q[0].flg <= vsum_q.flg;
    end
  end

  for (genvar k = 1; k <= TDIV_STEPS; k++) begin : g_tdiv
    always_ff @(posedge clk_i) begin
      if (adv) td_q[k] <= tdiv_step(td_q[k-1]);
    end
  end

  // ---- integer square root, one root bit per stage
  sqrt_t sq_init;
  sqrt_t sq_q [SQRT_STEPS];

  always_comb begin
    sq_init.x    = td_q[TDIV_STEPS].sh;
    sq_init.root = '0;
    sq_init.rem  = '0;
    sq_init.ovf  = td_q[TDIV_STEPS].ovf;
    sq_init.flg  = td_q[TDIV_STEPS].flg;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (adv) sq_q[0] <= sqrt_step(sq_init);
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (adv) sq_q[k] <= sqrt_step(sq_q[k-1]);
      end
    end
  end

  // ---- freedom branch: limb multiplies
  // group 0: w1 = v1*b, w2 = v2*a, Va = V*a
  // group 1: d1 = v1*w1, d2 = v2*w2, P = Va*b
  // group 2: num0 = P*V, den = d1 + d2 rides alongside
  mop_t   mop    [MUL_GROUPS][MUL_LANES];
  pp_t    pp_q   [MUL_GROUPS][MUL_LANES];
  rows_t  rows_q [MUL_GROUPS][MUL_LANES];
  prod_t  prod_q [MUL_GROUPS][MUL_LANES];
  fside_t fs_in  [MUL_GROUPS];
  fside_t fs_q   [MUL_GROUPS][MUL_DEPTH];
  fside_t fs_den;

  assign mop[0][0] = '{x: (32*MUL_XL)'(vsum_q.v1), y: (32*MUL_YL)'(vsum_q.b)};
  assign mop[0][1] = '{x: (32*MUL_XL)'(vsum_q.v2), y: (32*MUL_YL)'(vsum_q.a)};
  assign mop[0][2] = '{x: (32*MUL_XL)'(vsum_q.vs), y: (32*MUL_YL)'(vsum_q.a)};
  assign fs_in[0]  = '{v1: vsum_q.v1, v2: vsum_q.v2, vs: vsum_q.vs,
                       a: vsum_q.a, b: vsum_q.b, den: '0};

  assign mop[1][0] = '{x: prod_q[0][0][32*MUL_XL-1:0],
                       y: (32*MUL_YL)'(fs_q[0][MUL_DEPTH-1].v1)};
  assign mop[1][1] = '{x: prod_q[0][1][32*MUL_XL-1:0],
                       y: (32*MUL_YL)'(fs_q[0][MUL_DEPTH-1].v2)};
  assign mop[1][2] = '{x: prod_q[0][2][32*MUL_XL-1:0],
                       y: (32*MUL_YL)'(fs_q[0][MUL_DEPTH-1].b)};
  assign fs_in[1]  = fs_q[0][MUL_DEPTH-1];

  always_comb begin
    fs_den     = fs_q[1][MUL_DEPTH-1];
    fs_den.den = 145'(prod_q[1][0]) + 145'(prod_q[1][1]);
  end

  assign mop[2][0] = '{x: prod_q[1][2][32*MUL_XL-1:0],
                       y: (32*MUL_YL)'(fs_q[1][MUL_DEPTH-1].vs)};
  assign mop[2][1] = '0;
  assign mop[2][2] = '0;
  assign fs_in[2]  = fs_den;

  for (genvar g = 0; g < MUL_GROUPS; g++) begin : g_mgrp
    for (genvar l = 0; l < MUL_LANES; l++) begin : g_lane
      always_ff @(posedge clk_i) begin
        if (adv) begin
          pp_q[g][l]   <= mul_pp(mop[g][l]);
          rows_q[g][l] <= mul_rows(pp_q[g][l]);
          prod_q[g][l] <= mul_sum(rows_q[g][l]);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        fs_q[g][0] <= fs_in[g];
        for (int s = 1; s < MUL_DEPTH; s++) fs_q[g][s] <= fs_q[g][s-1];
      end
    end
  end

  // ---- floor(num0 * 2^16 / den), 32 quotient bits
  prod_t num0;
  fdiv_t fd_q [FDIV_STEPS+1];
  assign num0 = prod_q[MUL_GROUPS-1][0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fd_q[0].rem <= num0[160:16];
      fd_q[0].sh  <= {num0[15:0], 16'h0};
      fd_q[0].den <= fs_q[MUL_GROUPS-1][MUL_DEPTH-1].den;
      fd_q[0].ovf <= num0[161:16] >= {1'b0, fs_q[MUL_GROUPS-1][MUL_DEPTH-1].den};
    end
  end

  for (genvar k = 1; k <= FDIV_STEPS; k++) begin : g_fdiv
    always_ff @(posedge clk_i) begin
      if (adv) fd_q[k] <= fdiv_step(fd_q[k-1]);
    end
  end

  // align freedom with the longer t branch
  fres_t fp_q [F_PAD];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fp_q[0] <= '{q: fd_q[FDIV_STEPS].sh, ovf: fd_q[FDIV_STEPS].ovf};
      for (int k = 1; k < F_PAD; k++) fp_q[k] <= fp_q[k-1];
    end
  end

  // ---- output register
  sqrt_t       so;
  fres_t       fr;
  logic [31:0] mag;
  logic [31:0] t_d, f_d, t_q, f_q;
  logic        clip_d, clip_q, zvar_q, few_q;

  assign so = sq_q[SQRT_STEPS-1];
  assign fr = fp_q[F_PAD-1];

  always_comb begin
    if (so.ovf) begin
      mag = so.flg.neg ? T_NEG_LIM : T_POS_LIM;
    end else begin
      mag = {1'b0, so.root};
    end
    if (so.flg.zvar) begin
      t_d    = '0;
      f_d    = '0;
      clip_d = 1'b0;
    end else begin
      t_d    = so.flg.neg ? 32'(32'd0 - mag) : mag;
      f_d    = so.flg.few ? 32'd0 : (fr.ovf ? F_SAT : fr.q);
      clip_d = so.ovf | (~so.flg.few & fr.ovf);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_q    <= t_d;
      f_q    <= f_d;
      clip_q <= clip_d;
      zvar_q <= so.flg.zvar;
      few_q  <= so.flg.few;
    end
  end

  assign valid_o         = out_vld_q;
  assign t_value_o       = signed'(t_q);
  assign freedom_o       = f_q;
  assign clipped_o       = clip_q;
  assign zero_variance_o = zvar_q;
  assign small_count_o   = few_q;

`ifndef SYNTHESIS
  a_zvar_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_variance_o |-> t_value_o == 0 && freedom_o == 0 && !clipped_o)
    else $error("zero variance result not cleared");

  a_few_freedom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && small_count_o |-> freedom_o == 0)
    else $error("small count with nonzero freedom");

  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && clipped_o |-> t_value_o == signed'(T_POS_LIM) ||
      t_value_o == signed'(T_NEG_LIM) || freedom_o == F_SAT)
    else $error("clip flag without saturated value");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(vld_q[NSTG-1]) && $stable(t_q))
    else $error("pipeline moved while held");
`endif

endmodule
